// File: hdl/i2crp_pkg.sv
package i2crp_pkg;

  // Event kinds on the input channel.
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_SHIFT = 2'd2;

  // Sequencer phases.
  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_IDLE     = 3'd0;
  localparam logic [PhaseW-1:0] PH_ADDR     = 3'd1;
  localparam logic [PhaseW-1:0] PH_SEND     = 3'd2;
  localparam logic [PhaseW-1:0] PH_REQ_ACK  = 3'd3;
  localparam logic [PhaseW-1:0] PH_CHK_ACK  = 3'd4;
  localparam logic [PhaseW-1:0] PH_REQ_DATA = 3'd5;
  localparam logic [PhaseW-1:0] PH_GET_DATA = 3'd6;

  // Bus actions requested from the shift logic.
  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_WAIT       = 3'd1;
  localparam logic [2:0] ACT_RX_ADDR    = 3'd2;
  localparam logic [2:0] ACT_SEND_ACK   = 3'd3;
  localparam logic [2:0] ACT_SAMPLE_ACK = 3'd4;
  localparam logic [2:0] ACT_TX         = 3'd5;
  localparam logic [2:0] ACT_RX_DATA    = 3'd6;

  // Notices reported with a result beat.
  localparam logic [1:0] NOTE_NONE      = 2'd0;
  localparam logic [1:0] NOTE_ADDRESSED = 2'd1;
  localparam logic [1:0] NOTE_FRESH     = 2'd2;
  localparam logic [1:0] NOTE_REPEATED  = 2'd3;

  localparam logic [7:0] GENERAL_CALL = 8'h00;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] bus_byte;
    logic       start_held;
    logic [7:0] read_data;
  } evt_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic [7:0] reg_index;
    logic       read_strobe;
    logic       write_strobe;
    logic [7:0] write_value;
    logic [1:0] notice;
  } res_t;

endpackage

// File: hdl/i2crp_if.sv
interface i2crp_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] bus_byte;
  logic       start_held;
  logic [7:0] read_data;

  modport source (output valid, output mode, output bus_byte, output start_held,
                  output read_data, input ready);
  modport sink (input valid, input mode, input bus_byte, input start_held,
                input read_data, output ready);
endinterface

interface i2crp_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] tx_byte;
  logic [7:0] reg_index;
  logic       read_strobe;
  logic       write_strobe;
  logic [7:0] write_value;
  logic [1:0] notice;

  modport source (output valid, output action, output tx_byte, output reg_index,
                  output read_strobe, output write_strobe, output write_value,
                  output notice, input ready);
  modport sink (input valid, input action, input tx_byte, input reg_index,
                input read_strobe, input write_strobe, input write_value,
                input notice, output ready);
endinterface

// File: hdl/i2c_target_register_pointer_fsm.sv
// Channel   Dir  Fields                                        Handshake
// evt_i     in   mode, bus_byte, start_held, read_data         valid/ready
// res_o     out  action, tx_byte, reg_index, read_strobe,      valid/ready
//                write_strobe, write_value, notice
// cfg       in   cfg_wdata_i (own address)                     cfg_we_i
//
// One beat is taken per cycle unless a stalled result keeps the event register full;
// a result follows its beat through the event register, then the result register.
// The sequencer state updates in the cycle an event moves into the result register.
// A stalled result holds; the event register still takes one more beat behind it.
// rst_ni clears the state, the own address and both valid flags asynchronously.
module i2c_target_register_pointer_fsm (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  i2crp_evt_if.sink   evt_i,
  i2crp_res_if.source res_o
);
  import i2crp_pkg::*;

  evt_t evt_q;
  logic evt_vld_q, evt_vld_d;
  res_t res_q, res_d;
  logic res_vld_q, res_vld_d;
  logic advance;
  logic evt_take;

  assign advance     = evt_vld_q && (!res_vld_q || res_o.ready);
  assign evt_i.ready = !evt_vld_q || advance;
  assign evt_take    = evt_i.valid && evt_i.ready;
  assign evt_vld_d   = evt_take || (evt_vld_q && !advance);
  assign res_vld_d   = advance || (res_vld_q && !res_o.ready);

  i2crp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_en_i  (advance),
    .evt_i      (evt_q),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      evt_vld_q <= evt_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_take) begin
      evt_q.mode       <= evt_i.mode;
      evt_q.bus_byte   <= evt_i.bus_byte;
      evt_q.start_held <= evt_i.start_held;
      evt_q.read_data  <= evt_i.read_data;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = res_vld_q;
  assign res_o.action       = res_q.action;
  assign res_o.tx_byte      = res_q.tx_byte;
  assign res_o.reg_index    = res_q.reg_index;
  assign res_o.read_strobe  = res_q.read_strobe;
  assign res_o.write_strobe = res_q.write_strobe;
  assign res_o.write_value  = res_q.write_value;
  assign res_o.notice       = res_q.notice;

endmodule

// File: hdl/i2crp_core.sv
module i2crp_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [6:0]     cfg_wdata_i,
  input  logic           step_en_i,
  input  i2crp_pkg::evt_t evt_i,
  output i2crp_pkg::res_t res_o
);
  import i2crp_pkg::*;

  logic [6:0]        own_addr_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [7:0]        ptr_q, ptr_d;
  logic [7:0]        wr_cnt_q, wr_cnt_d;
  logic              stop_pend_q, stop_pend_d;
  logic              addr_hit;
  logic              nack;

  assign addr_hit = (evt_i.bus_byte == GENERAL_CALL) || (evt_i.bus_byte[7:1] == own_addr_q);
  assign nack     = (evt_i.bus_byte != 8'h00);

  always_comb begin
    phase_d     = phase_q;
    ptr_d       = ptr_q;
    wr_cnt_d    = wr_cnt_q;
    stop_pend_d = stop_pend_q;
    res_o       = '0;

    unique case (evt_i.mode)
      MODE_START: begin
        if (stop_pend_q) begin
          ptr_d        = '0;
          wr_cnt_d     = '0;
          res_o.notice = NOTE_FRESH;
        end else begin
          res_o.notice = NOTE_REPEATED;
        end
        stop_pend_d = 1'b0;
        if (evt_i.start_held) begin
          phase_d      = PH_ADDR;
          res_o.action = ACT_RX_ADDR;
        end else begin
          phase_d      = PH_IDLE;
          res_o.action = ACT_WAIT;
        end
      end
      MODE_STOP: begin
        stop_pend_d  = 1'b1;
        phase_d      = PH_IDLE;
        res_o.action = ACT_WAIT;
      end
      MODE_SHIFT: begin
        unique case (phase_q)
          PH_ADDR: begin
            if (addr_hit) begin
              phase_d      = evt_i.bus_byte[0] ? PH_SEND : PH_REQ_DATA;
              res_o.action = ACT_SEND_ACK;
              res_o.notice = NOTE_ADDRESSED;
            end else begin
              phase_d      = PH_IDLE;
              res_o.action = ACT_WAIT;
            end
          end
          PH_SEND, PH_CHK_ACK: begin
            // A nonzero ack sample is a NACK and ends the read.
            if (phase_q == PH_CHK_ACK && nack) begin
              phase_d      = PH_IDLE;
              res_o.action = ACT_WAIT;
            end else begin
              res_o.action      = ACT_TX;
              res_o.tx_byte     = evt_i.read_data;
              res_o.reg_index   = ptr_q;
              res_o.read_strobe = 1'b1;
              ptr_d             = ptr_q + 8'd1;
              phase_d           = PH_REQ_ACK;
            end
          end
          PH_REQ_ACK: begin
            phase_d      = PH_CHK_ACK;
            res_o.action = ACT_SAMPLE_ACK;
          end
          PH_REQ_DATA: begin
            phase_d      = PH_GET_DATA;
            res_o.action = ACT_RX_DATA;
          end
          PH_GET_DATA: begin
            // A data byte taken while the write count is zero loads the register pointer.
            if (wr_cnt_q == 8'd0) begin
              ptr_d = evt_i.bus_byte;
            end else begin
              res_o.reg_index    = ptr_q;
              res_o.write_strobe = 1'b1;
              res_o.write_value  = evt_i.bus_byte;
              ptr_d              = ptr_q + 8'd1;
            end
            wr_cnt_d     = wr_cnt_q + 8'd1;
            phase_d      = PH_REQ_DATA;
            res_o.action = ACT_SEND_ACK;
          end
          default: begin
            phase_d      = PH_IDLE;
            res_o.action = ACT_NONE;
          end
        endcase
      end
      default: begin
        res_o.action = ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q  <= '0;
      phase_q     <= PH_IDLE;
      ptr_q       <= '0;
      wr_cnt_q    <= '0;
      stop_pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        own_addr_q <= cfg_wdata_i;
      end
      if (step_en_i) begin
        phase_q     <= phase_d;
        ptr_q       <= ptr_d;
        wr_cnt_q    <= wr_cnt_d;
        stop_pend_q <= stop_pend_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 3'd7)
    else $error("sequencer reached an unused phase");

  a_stop_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && evt_i.mode == MODE_STOP |=> stop_pend_q && phase_q == PH_IDLE)
    else $error("stop did not leave the sequencer idle with a pending stop");

  a_write_after_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res_o.write_strobe |-> wr_cnt_q != 8'd0 && phase_q == PH_GET_DATA)
    else $error("register write before the pointer byte");

  a_read_is_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && res_o.read_strobe |=> phase_q == PH_REQ_ACK && ptr_q == $past(ptr_q) + 8'd1)
    else $error("transmit did not advance the pointer");
`endif

endmodule

// File: bench/i2crp_checker.sv
`timescale 1ns / 100ps

module i2crp_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  i2crp_evt_if       evt,
  i2crp_res_if       res,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);
  import i2crp_pkg::*;

  // Mirror of the sequencer state.
  logic [PhaseW-1:0] bus_phase;
  logic [7:0]        pointer;
  logic [7:0]        byte_count;
  logic              stop_seen;
  logic [6:0]        own_addr;

  res_t expected_q[$];
  res_t want;
  evt_t beat;

  function automatic res_t next_response(evt_t e);
    res_t r;
    r = '0;
    case (e.mode)
      MODE_START: begin
        if (stop_seen) begin
          pointer = 8'd0;
          byte_count = 8'd0;
          r.notice = NOTE_FRESH;
        end else begin
          r.notice = NOTE_REPEATED;
        end
        stop_seen = 1'b0;
        if (e.start_held) begin
          bus_phase = PH_ADDR;
          r.action = ACT_RX_ADDR;
        end else begin
          bus_phase = PH_IDLE;
          r.action = ACT_WAIT;
        end
      end
      MODE_STOP: begin
        stop_seen = 1'b1;
        bus_phase = PH_IDLE;
        r.action = ACT_WAIT;
      end
      MODE_SHIFT: begin
        case (bus_phase)
          PH_ADDR: begin
            if (e.bus_byte == GENERAL_CALL || e.bus_byte[7:1] == own_addr) begin
              bus_phase = e.bus_byte[0] ? PH_SEND : PH_REQ_DATA;
              r.action = ACT_SEND_ACK;
              r.notice = NOTE_ADDRESSED;
            end else begin
              bus_phase = PH_IDLE;
              r.action = ACT_WAIT;
            end
          end
          PH_SEND, PH_CHK_ACK: begin
            // Any nonzero ack sample is a NACK and ends the read.
            if (bus_phase == PH_CHK_ACK && e.bus_byte != 8'd0) begin
              bus_phase = PH_IDLE;
              r.action = ACT_WAIT;
            end else begin
              r.action = ACT_TX;
              r.tx_byte = e.read_data;
              r.reg_index = pointer;
              r.read_strobe = 1'b1;
              pointer = pointer + 8'd1;
              bus_phase = PH_REQ_ACK;
            end
          end
          PH_REQ_ACK: begin
            bus_phase = PH_CHK_ACK;
            r.action = ACT_SAMPLE_ACK;
          end
          PH_REQ_DATA: begin
            bus_phase = PH_GET_DATA;
            r.action = ACT_RX_DATA;
          end
          PH_GET_DATA: begin
            // The first byte after a fresh start loads the pointer.
            if (byte_count == 8'd0) begin
              pointer = e.bus_byte;
            end else begin
              r.reg_index = pointer;
              r.write_strobe = 1'b1;
              r.write_value = e.bus_byte;
              pointer = pointer + 8'd1;
            end
            byte_count = byte_count + 8'd1;
            bus_phase = PH_REQ_DATA;
            r.action = ACT_SEND_ACK;
          end
          default: begin
            bus_phase = PH_IDLE;
            r.action = ACT_NONE;
          end
        endcase
      end
      default: r.action = ACT_NONE;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o = fail_count_o + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_phase = PH_IDLE;
      pointer = 8'd0;
      byte_count = 8'd0;
      stop_seen = 1'b0;
      own_addr = 7'd0;
      expected_q.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no event waiting for it");
          fail_count_o = fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          check_field("action", 8'(want.action), 8'(res.action));
          check_field("tx_byte", want.tx_byte, res.tx_byte);
          check_field("reg_index", want.reg_index, res.reg_index);
          check_field("read_strobe", 8'(want.read_strobe), 8'(res.read_strobe));
          check_field("write_strobe", 8'(want.write_strobe), 8'(res.write_strobe));
          check_field("write_value", want.write_value, res.write_value);
          check_field("notice", 8'(want.notice), 8'(res.notice));
          checked_o = checked_o + 1;
        end
      end
      if (cfg_we_i) begin
        own_addr = cfg_wdata_i;
      end
      if (evt.valid && evt.ready) begin
        beat = {evt.mode, evt.bus_byte, evt.start_held, evt.read_data};
        expected_q.push_back(next_response(beat));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// File: bench/tb_i2c_target_register_pointer_fsm.sv
`timescale 1ns / 100ps

module tb_i2c_target_register_pointer_fsm;
  import i2crp_pkg::*;

  localparam int ITEMS = 1250;
  localparam int CFG_SPACING = 220;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  i2crp_evt_if evt ();
  i2crp_res_if res ();

  int fail_count;
  int pending;
  int checked;
  int sent;
  int addr_writes;
  bit calm;
  bit long_hold;
  logic [6:0] cur_addr;

  i2c_target_register_pointer_fsm uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .evt_i      (evt),
    .res_o      (res)
  );

  i2crp_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .evt         (evt),
    .res         (res),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #800000;
    $display("tb_i2c_target_register_pointer_fsm: errors");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    res.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        res.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Entered just after the edge that took the previous beat.
  task automatic put_evt(input logic [1:0] m, input logic [7:0] b, input logic h,
                         input logic [7:0] rd);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      evt.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    evt.valid <= 1'b1;
    evt.mode <= m;
    evt.bus_byte <= b;
    evt.start_held <= h;
    evt.read_data <= rd;
    do @(posedge clk_i); while (!evt.ready);
    sent++;
  endtask

  task automatic bus_start(input logic h);
    put_evt(MODE_START, 8'($urandom), h, 8'($urandom));
  endtask

  task automatic bus_stop();
    put_evt(MODE_STOP, 8'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic bus_shift(input logic [7:0] b);
    put_evt(MODE_SHIFT, b, 1'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    @(negedge clk_i);
    evt.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Called at a falling edge with the block idle.
  task automatic set_addr(input logic [6:0] a);
    cfg_we <= 1'b1;
    cfg_wdata <= a;
    cur_addr = a;
    addr_writes++;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_txn(input int n, input bit general);
    if ($urandom_range(0, 1) == 1) bus_stop();
    bus_start(1'b1);
    bus_shift(general ? GENERAL_CALL : {cur_addr, 1'b0});
    for (int i = 0; i < n; i++) begin
      bus_shift(8'($urandom));
      bus_shift(8'($urandom));
    end
    if ($urandom_range(0, 2) == 0) bus_stop();
  endtask

  task automatic read_txn(input int n);
    bus_start(1'b1);
    bus_shift({cur_addr, 1'b1});
    for (int i = 0; i < n; i++) begin
      bus_shift(8'($urandom));
      bus_shift(8'($urandom));
      bus_shift((i == n - 1) ? 8'($urandom_range(1, 255)) : 8'd0);
    end
    if ($urandom_range(0, 1) == 1) bus_stop();
  endtask

  task automatic broken_txn();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: bus_start(1'b0);
      1: begin
        do b = 8'($urandom); while (b == GENERAL_CALL || b[7:1] == cur_addr);
        bus_start(1'b1);
        bus_shift(b);
      end
      2: begin
        bus_start(1'b1);
        bus_shift({cur_addr, 1'b1});
        bus_shift(8'($urandom));
        bus_stop();
      end
      default: begin
        bus_start(1'b1);
        bus_shift({cur_addr, 1'b0});
        bus_shift(8'($urandom));
        bus_stop();
      end
    endcase
  endtask

  initial begin
    logic [6:0] addr_list[5];
    int next_cfg;
    int pick;
    int k;
    addr_list = '{7'h00, 7'h7F, 7'h2A, 7'h55, 7'h00};
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 7'd0;
    evt.valid = 1'b0;
    evt.mode = MODE_START;
    evt.bus_byte = 8'd0;
    evt.start_held = 1'b0;
    evt.read_data = 8'd0;
    sent = 0;
    addr_writes = 0;
    calm = 1'b0;
    long_hold = 1'b0;
    cur_addr = 7'd0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    set_addr(7'h7F);

    // Directed: idle shift, unknown mode, starts with and without a prior stop,
    // address mismatch, write with pointer wrap, read ended by a stop, general call.
    bus_shift(8'hFF);
    put_evt(2'd3, 8'hFF, 1'b1, 8'hFF);
    bus_start(1'b0);
    bus_stop();
    bus_start(1'b1);
    bus_shift({7'h12, 1'b0});
    bus_start(1'b1);
    bus_shift({7'h7F, 1'b0});
    bus_shift(8'h00);
    bus_shift(8'hFE);
    bus_shift(8'h00);
    bus_shift(8'h00);
    bus_shift(8'h00);
    bus_shift(8'hFF);
    bus_shift(8'h00);
    bus_shift(8'hA5);
    bus_start(1'b1);
    bus_shift({7'h7F, 1'b1});
    put_evt(MODE_SHIFT, 8'h00, 1'b0, 8'hFF);
    bus_shift(8'h00);
    bus_shift(8'h00);
    put_evt(MODE_SHIFT, 8'hFF, 1'b1, 8'h00);
    bus_shift(8'h00);
    bus_shift(8'h80);
    bus_stop();
    bus_start(1'b1);
    bus_shift(GENERAL_CALL);
    put_evt(2'd3, 8'h00, 1'b0, 8'h00);
    drain();
    set_addr(7'h00);

    // Long write after a stop so that the byte counter wraps past 255.
    long_hold = 1'b1;
    bus_stop();
    bus_start(1'b1);
    bus_shift(GENERAL_CALL);
    for (int i = 0; i < 262; i++) begin
      bus_shift(8'($urandom));
      bus_shift(8'($urandom));
    end

    k = 0;
    next_cfg = sent + CFG_SPACING;
    while (sent < ITEMS) begin
      if (sent >= next_cfg) begin
        drain();
        set_addr((k == 2) ? 7'($urandom) : addr_list[k % 5]);
        k++;
        next_cfg = sent + CFG_SPACING;
      end
      calm = (sent > ITEMS - 150);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        write_txn($urandom_range(1, 6), $urandom_range(0, 9) == 0);
      end else if (pick < 75) begin
        read_txn($urandom_range(1, 6));
      end else if (pick < 88) begin
        broken_txn();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          put_evt(2'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
        end
      end
    end

    drain();
    repeat (10) @(negedge clk_i);
    $display("Run covered %0d event beats and %0d checked result beats", sent, checked);
    $display("across %0d own-address settings, with reads, writes and broken frames.",
             addr_writes);
    if (fail_count == 0) begin
      $display("tb_i2c_target_register_pointer_fsm: clean");
    end else begin
      $display("tb_i2c_target_register_pointer_fsm: errors");
    end
    $finish;
  end

endmodule
